// ===== design/bha_pkg.sv =====
package bha_pkg;

  localparam int PAGE_BITS = 64;
  localparam int PG_W      = 8;    // page counters: up to 128 pages for a 13-bit heap size
  localparam int WIDX_W    = 14;   // word index with room for an exclusive end

  localparam logic [63:0] FULL_PAGE = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] CFG_REG_HEAP = 3'd0;

  typedef struct packed {
    logic [1:0]  op;
    logic [12:0] word_count;
    logic [11:0] mark_start;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] start_index;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_FILL,
    S_MRD,
    S_MWR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan;
    logic fill;
    logic mrd;
    logic mwr;
    logic clear;
    logic res_ok;
    logic res_fail;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       alloc_bad;
    logic       mark_any;
    logic       need_fill;
    logic       hit;
    logic       miss;
    logic       fill_last;
    logic       mark_last;
    logic       out_free;
  } sts_t;

  // Ones in the low n bits, n from 0 to 64.
  function automatic logic [63:0] low_mask(input logic [6:0] n);
    logic [63:0] m;
    if (n[6]) begin
      m = FULL_PAGE;
    end else begin
      m = ~(FULL_PAGE << n[5:0]);
    end
    return m;
  endfunction

endpackage

// ===== design/bha_ctrl.sv =====
module bha_ctrl
  import bha_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        case (sts.op)
          OP_ALLOC: state_nxt = sts.alloc_bad ? S_DONE : S_SCAN;
          OP_MARK:  state_nxt = sts.mark_any ? S_MRD : S_DONE;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (sts.hit) begin
          state_nxt = sts.need_fill ? S_FILL : S_DONE;
        end else if (sts.miss) begin
          state_nxt = S_DONE;
        end
      end
      S_FILL: begin
        if (sts.fill_last) state_nxt = S_DONE;
      end
      S_MRD: state_nxt = S_MWR;
      S_MWR: state_nxt = sts.mark_last ? S_DONE : S_MRD;
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SETUP: begin
        case (sts.op)
          OP_ALLOC: begin
            cmd.res_fail  = sts.alloc_bad;
            cmd.scan_init = !sts.alloc_bad;
          end
          OP_MARK: cmd.res_ok = 1'b1;
          OP_CLEAR: begin
            cmd.clear  = 1'b1;
            cmd.res_ok = 1'b1;
          end
          default: cmd.res_fail = 1'b1;
        endcase
      end
      S_SCAN: begin
        cmd.scan     = 1'b1;
        cmd.res_fail = sts.miss && !sts.hit;
      end
      S_FILL:  cmd.fill    = 1'b1;
      S_MRD:   cmd.mrd     = 1'b1;
      S_MWR:   cmd.mwr     = 1'b1;
      S_DONE:  cmd.publish = sts.out_free;
      default: cmd         = '0;
    endcase
  end

endmodule

// ===== design/bha_dpath.sv =====
module bha_dpath
  import bha_pkg::*;
#(
  parameter int NPAGES = 64,
  parameter int AW     = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  in_item_t    in_data,
  input  logic [12:0] eff_size,
  input  logic [7:0]  eff_pages,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  // page store; a page never written since reset or clear reads as zero
  logic [63:0]       mem_r [NPAGES];
  logic [NPAGES-1:0] valid_r;
  logic [63:0]       rdata_r;
  logic              rvld_r;

  logic [1:0]        op_r;
  logic [12:0]       cnt_r;
  logic              large_r;
  logic [PG_W-1:0]   req_r;
  logic [6:0]        trail_r;
  logic [63:0]       smask_r;
  logic [WIDX_W-1:0] lo_r, hi_r;
  logic              many_r;
  logic [PG_W-1:0]   mptr_r, mlast_r;
  logic [PG_W-1:0]   iss_r, evp_r, run_r, fptr_r, fend_r;
  logic              dv_r;
  logic              res_ok_r;
  logic [11:0]       res_idx_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [WIDX_W-1:0] sum_w, hi_w, base_w, lo_in_w, hi_in_w;
  logic [WIDX_W-1:0] rnd_w, req_w, trail_w;
  logic [63:0]       page_q, fit_shift, mmask, tmask;
  logic [63:0]       fit;
  logic [5:0]        pos;
  logic              any_fit, hit_small, hit_large, hit, issue;
  logic              re, we;
  logic [PG_W-1:0]   raddr, waddr;
  logic [63:0]       wdata;

  // derived operands, taken at load
  always_comb begin
    sum_w   = WIDX_W'(in_data.mark_start) + WIDX_W'(in_data.word_count);
    hi_w    = (sum_w < WIDX_W'(eff_size)) ? sum_w : WIDX_W'(eff_size);
    rnd_w   = (WIDX_W'(in_data.word_count) + WIDX_W'(PAGE_BITS - 1)) >> 6;
    req_w   = rnd_w - WIDX_W'(1);
    trail_w = WIDX_W'(in_data.word_count) - (req_w << 6);
  end

  assign page_q = rvld_r ? rdata_r : '0;

  // first fit inside one page: lowest position whose window is free
  always_comb begin
    for (int b = 0; b < PAGE_BITS; b++) begin
      fit[b] = ((b + int'(cnt_r[5:0])) <= PAGE_BITS) && (((page_q >> b) & smask_r) == '0);
    end
    pos = '0;
    for (int b = PAGE_BITS - 1; b >= 0; b--) begin
      if (fit[b]) pos = 6'(b);
    end
    any_fit   = |fit;
    fit_shift = smask_r << pos;
  end

  assign tmask     = low_mask(trail_r);
  assign hit_small = dv_r && !large_r && any_fit;
  assign hit_large = dv_r && large_r && (run_r >= req_r) && ((page_q & tmask) == '0);
  assign hit       = cmd.scan && (hit_small || hit_large);
  assign issue     = cmd.scan && (iss_r < eff_pages);

  // mark mask of the page under the mark pointer
  always_comb begin
    base_w  = WIDX_W'({mptr_r, 6'b0});
    lo_in_w = (lo_r > base_w) ? (lo_r - base_w) : '0;
    hi_in_w = ((hi_r - base_w) >= WIDX_W'(PAGE_BITS)) ? WIDX_W'(PAGE_BITS) : (hi_r - base_w);
    mmask   = low_mask(7'(hi_in_w)) & ~low_mask(7'(lo_in_w));
  end

  // memory port muxing
  always_comb begin
    re    = issue || cmd.mrd;
    raddr = cmd.mrd ? mptr_r : iss_r;
    we    = 1'b0;
    waddr = evp_r;
    wdata = page_q | (large_r ? tmask : fit_shift);
    if (hit) begin
      we = 1'b1;
    end else if (cmd.fill) begin
      we    = 1'b1;
      waddr = fptr_r;
      wdata = FULL_PAGE;
    end else if (cmd.mwr) begin
      we    = 1'b1;
      waddr = mptr_r;
      wdata = page_q | mmask;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem_r[AW'(waddr)] <= wdata;
    if (re) rdata_r <= mem_r[AW'(raddr)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[AW'(waddr)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) rvld_r <= valid_r[AW'(raddr)];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_data.op;
      cnt_r   <= in_data.word_count;
      large_r <= (in_data.word_count >= 13'(PAGE_BITS));
      req_r   <= PG_W'(req_w);
      trail_r <= 7'(trail_w);
      smask_r <= low_mask({1'b0, in_data.word_count[5:0]});
      lo_r    <= WIDX_W'(in_data.mark_start);
      hi_r    <= hi_w;
      many_r  <= (WIDX_W'(in_data.mark_start) < hi_w);
      mptr_r  <= PG_W'(in_data.mark_start[11:6]);
      mlast_r <= PG_W'((hi_w - WIDX_W'(1)) >> 6);
    end else if (cmd.mwr) begin
      mptr_r <= mptr_r + PG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      iss_r <= '0;
      dv_r  <= 1'b0;
      run_r <= '0;
    end else if (cmd.scan) begin
      if (issue) iss_r <= iss_r + PG_W'(1);
      dv_r  <= issue;
      evp_r <= iss_r;
      if (dv_r) run_r <= (page_q == '0) ? run_r + PG_W'(1) : '0;
    end
    if (hit) begin
      fptr_r <= evp_r - req_r;
      fend_r <= evp_r;
    end else if (cmd.fill) begin
      fptr_r <= fptr_r + PG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      res_ok_r  <= 1'b1;
      res_idx_r <= large_r ? 12'({evp_r - req_r, 6'b0}) : 12'({evp_r, pos});
    end else if (cmd.res_ok || cmd.res_fail) begin
      res_ok_r  <= cmd.res_ok;
      res_idx_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) out_r <= '{ok: res_ok_r, start_index: res_idx_r};
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts.op        = op_r;
    sts.alloc_bad = (cnt_r == '0) || (large_r && (cnt_r > eff_size));
    sts.mark_any  = many_r;
    sts.need_fill = large_r && (req_r != '0);
    sts.hit       = hit_small || hit_large;
    sts.miss      = !dv_r && (iss_r >= eff_pages);
    sts.fill_last = (fptr_r + PG_W'(1)) == fend_r;
    sts.mark_last = (mptr_r == mlast_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

endmodule

// ===== design/bitmap_heap_allocator_unit.sv =====
// Bitmap heap allocator. One usage bit per heap word, kept in 64-bit pages in
// an on-chip page memory. An op beat allocates (first fit: 1..63 words inside
// one page, 64 or more words as empty whole pages plus a free low part of the
// next page), marks a word range used (clipped at heap end) or clears every
// mark; each beat yields exactly one result beat (ok, start_index). Items are
// worked one at a time. The allocation scan reads one page per cycle from the
// single-read-port page memory, scanning pages = ceil(heap_size_words / 64),
// up to 64 by default; a large request then writes each whole page it takes
// as full. A mark reads and then writes back each touched page in turn. The
// next op beat is taken as soon as the result sits in the output register,
// even if it has not been taken yet.
// heap_size_words lives at byte address 0 of the APB port and may be written
// only while the unit is idle.
module bitmap_heap_allocator_unit
  import bha_pkg::*;
#(
  parameter int HEAP_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NPAGES = (HEAP_WORDS + PAGE_BITS - 1) / PAGE_BITS;
  localparam int AW     = (NPAGES > 1) ? $clog2(NPAGES) : 1;

  logic [12:0] heap_size_r;
  logic [12:0] eff_size;
  logic [7:0]  eff_pages;
  logic        reg_sel;
  cmd_t        cmd;
  sts_t        sts;

  // register select by word address
  assign reg_sel = ({paddr[2], 2'b00} == CFG_REG_HEAP);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {19'b0, heap_size_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_size_r <= 13'd4096;
    end else if (psel && penable && pwrite && reg_sel) begin
      heap_size_r <= pwdata[12:0];
    end
  end

  // clip the configured size to the built heap; round up to whole pages
  assign eff_size  = (32'(heap_size_r) > HEAP_WORDS) ? 13'(HEAP_WORDS) : heap_size_r;
  assign eff_pages = 8'((14'(eff_size) + 14'(PAGE_BITS - 1)) >> 6);

  bha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bha_dpath #(
    .NPAGES (NPAGES),
    .AW     (AW)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .eff_size  (eff_size),
    .eff_pages (eff_pages),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/bha_checker.sv =====
module bha_checker
  import bha_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // busy right after an op beat is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("op beat taken while busy");

  // a failed result carries a zero index
  a_fail_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.start_index == '0)
    else $error("failure with nonzero index");

  // a result appears only from a busy unit
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work");

endmodule

bind bitmap_heap_allocator_unit bha_checker u_bha_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/bitmap_heap_allocator_unit_test.sv =====
module bitmap_heap_allocator_unit_test;
  import bha_pkg::*;

  localparam int MAX_WORDS  = 4096;
  localparam int MAX_PAGES  = MAX_WORDS / PAGE_BITS;
  // Longest op is a mark over the whole heap, which reads and writes back every page.
  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT  = 20000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bitmap_heap_allocator_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the usage bitmap and the heap size register.
  logic [63:0] shadow_pages [MAX_PAGES];
  logic [12:0] shadow_heap_words;
  out_item_t   pending_results [$];

  int error_count;
  int stall_cycles;
  int send_idle_pct;
  int recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic int heap_words();
    return (shadow_heap_words > MAX_WORDS) ? MAX_WORDS : int'(shadow_heap_words);
  endfunction

  function automatic logic [63:0] ones_below(input int n);
    return (n >= 64) ? FULL_PAGE : ((64'd1 << n) - 64'd1);
  endfunction

  // First fit inside one page; -1 when nothing fits.
  function automatic int first_fit_in_page(input int count, input int pages);
    logic [63:0] m;
    m = ones_below(count);
    for (int p = 0; p < pages; p++) begin
      for (int b = 0; b + count <= PAGE_BITS; b++) begin
        if ((shadow_pages[p] & (m << b)) == 64'd0) return p * PAGE_BITS + b;
      end
    end
    return -1;
  endfunction

  function automatic int empty_pages_from(input int from, input int pages);
    int n;
    n = 0;
    while (from + n < pages && shadow_pages[from + n] == 64'd0) n++;
    return n;
  endfunction

  // Run of empty pages plus a free low part of the trailing page.
  function automatic int first_fit_pages(input int count, input int pages);
    int whole, tail, p, run;
    if (count > heap_words()) return -1;
    whole = (count + PAGE_BITS - 1) / PAGE_BITS - 1;
    tail  = count - whole * PAGE_BITS;
    if (whole > pages) return -1;
    p = 0;
    while (p < pages - whole) begin
      run = empty_pages_from(p, pages);
      if (run > whole) return p * PAGE_BITS;
      if (run == whole && p + whole < pages &&
          (shadow_pages[p + whole] & ones_below(tail)) == 64'd0)
        return p * PAGE_BITS;
      p += (run > 1) ? run : 1;
    end
    return -1;
  endfunction

  function automatic void claim_range(input int addr, input int count);
    int whole, page, shift, tail;
    whole = (count + PAGE_BITS - 1) / PAGE_BITS - 1;
    page  = addr / PAGE_BITS;
    shift = addr % PAGE_BITS;
    tail  = count - whole * PAGE_BITS;
    for (int i = page; i < page + whole && i < MAX_PAGES; i++) shadow_pages[i] = FULL_PAGE;
    if (page + whole < MAX_PAGES) shadow_pages[page + whole] |= ones_below(tail) << shift;
  endfunction

  // Work out the result of one op beat and update the shadow bitmap.
  function automatic out_item_t heap_op_result(input in_item_t item);
    out_item_t r;
    int pages, addr, count, w;
    r = '0;
    count = int'(item.word_count);
    case (item.op)
      OP_ALLOC: begin
        pages = (heap_words() + PAGE_BITS - 1) / PAGE_BITS;
        addr = -1;
        if (count > 0) begin
          addr = (count < PAGE_BITS) ? first_fit_in_page(count, pages)
                                     : first_fit_pages(count, pages);
        end
        if (addr >= 0) begin
          claim_range(addr, count);
          r.ok = 1'b1;
          r.start_index = addr[11:0];
        end
      end
      OP_MARK: begin
        for (int i = 0; i < count; i++) begin
          w = int'(item.mark_start) + i;
          if (w >= heap_words()) break;
          shadow_pages[w / PAGE_BITS][w % PAGE_BITS] = 1'b1;
        end
        r.ok = 1'b1;
      end
      OP_CLEAR: begin
        for (int p = 0; p < MAX_PAGES; p++) shadow_pages[p] = 64'd0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sample at the falling edge: ready/valid were set at the last rising edge
  // and stay put until the next one, so a beat seen here is taken next edge.
  always @(negedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) pending_results.push_back(heap_op_result(in_data));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result beat, start_index",
                          out_data.start_index, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.ok !== want.ok) report_mismatch("ok", out_data.ok, want.ok);
          if (out_data.start_index !== want.start_index)
            report_mismatch("start_index", out_data.start_index, want.start_index);
        end
      end
      // Watchdog: count cycles in which no beat moves on either channel and no APB access runs.
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // Receiver: stall at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one op beat; hold valid and payload until the beat is taken.
  task automatic send_op(input logic [1:0] op, input int count, input int start);
    logic rdy;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.op <= op;
    in_data.word_count <= count[12:0];
    in_data.mark_start <= start[11:0];
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // Drain all results, then let the unit settle before touching the register.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_heap_size(input int words);
    wait_idle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {CFG_REG_HEAP[0], 2'b00};
    pwdata <= words;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_heap_words = words[12:0];
  endtask

  task automatic test_zero_and_full_heap();
    write_heap_size(4096);
    send_op(OP_ALLOC, 0, 0);        // zero-word allocation fails
    send_op(OP_ALLOC, 1, 0);
    send_op(OP_ALLOC, 63, 0);
    send_op(OP_ALLOC, 64, 0);
    send_op(OP_ALLOC, 4096, 0);     // no room: heap partly used
    send_op(OP_ALLOC, 8191, 4095);  // above heap size
    send_op(OP_UNUSED, 8191, 4095); // ignored op code
    send_op(OP_CLEAR, 0, 0);
    send_op(OP_ALLOC, 4096, 0);     // whole heap
    send_op(OP_ALLOC, 1, 0);        // nothing left
    send_op(OP_CLEAR, 4096, 4095);
    send_op(OP_MARK, 0, 0);
    send_op(OP_MARK, 20, 10);
    send_op(OP_ALLOC, 63, 0);
    send_op(OP_MARK, 4096, 4095);   // clipped at heap end
    send_op(OP_ALLOC, 64, 0);
  endtask

  task automatic test_edge_heap_sizes();
    write_heap_size(70);            // small allocation runs past heap end
    send_op(OP_CLEAR, 0, 0);
    send_op(OP_ALLOC, 63, 0);
    send_op(OP_ALLOC, 63, 0);
    send_op(OP_MARK, 100, 65);      // start inside heap, clipped at heap end
    write_heap_size(128);           // trailing page blocked
    send_op(OP_CLEAR, 0, 0);
    send_op(OP_MARK, 1, 64);
    send_op(OP_ALLOC, 100, 0);
    send_op(OP_ALLOC, 65, 0);
    write_heap_size(0);             // no pages at all
    send_op(OP_ALLOC, 1, 0);
    write_heap_size(8191);          // acts as the full heap
    send_op(OP_CLEAR, 0, 0);
    send_op(OP_ALLOC, 4096, 0);
  endtask

  // Mostly allocations with occasional marks and clears so the heap keeps
  // cycling between empty, fragmented and full.
  task automatic run_random(input int heap, input int n, input int s_idle, input int r_idle);
    int pick, hw;
    write_heap_size(heap);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    hw = heap_words();
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 40)      send_op(OP_ALLOC, $urandom_range(1, 8), $urandom_range(4095));
      else if (pick < 55) send_op(OP_ALLOC, $urandom_range(1, 63), $urandom_range(4095));
      else if (pick < 67) send_op(OP_ALLOC, $urandom_range(64, (hw > 64) ? hw : 64),
                                  $urandom_range(4095));
      else if (pick < 82) send_op(OP_MARK, $urandom_range(0, 40), $urandom_range(4095));
      else if (pick < 85) send_op(OP_MARK, $urandom_range(8191), $urandom_range(4095));
      else if (pick < 90) send_op(OP_CLEAR, $urandom_range(8191), $urandom_range(4095));
      else if (pick < 92) send_op(OP_UNUSED, $urandom_range(8191), $urandom_range(4095));
      else                send_op(OP_ALLOC, $urandom_range(8191), $urandom_range(4095));
    end
  endtask

  initial begin
    error_count = 0;
    stall_cycles = 0;
    send_idle_pct = 22;
    recv_idle_pct = 63;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    shadow_heap_words = 13'd4096;
    for (int p = 0; p < MAX_PAGES; p++) shadow_pages[p] = 64'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_and_full_heap();
    test_edge_heap_sizes();
    run_random(4096, 350, 22, 63);
    run_random(300,  250, 22, 63);
    run_random(777,  250, 63, 22);
    run_random(1,    100, 63, 22);
    run_random(8191, 300, 0, 0);
    run_random(130,  300, 0, 0);
    run_random(64,   100, 0, 0);

    // Drain, bounded by the watchdog.
    wait_idle();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bha_pkg.sv
design/bha_ctrl.sv
design/bha_dpath.sv
design/bitmap_heap_allocator_unit.sv
design/bha_checker.sv
tb/sv/bitmap_heap_allocator_unit_test.sv
